[design/gaab_pkg.sv]
// ----------------------------------------------------------------------------
// gaab_pkg
// Shared types and constants for the glyph alpha blend blitter: register
// map, ARGB8888 field layout and the staged pixel word.
// ----------------------------------------------------------------------------
package gaab_pkg;

    // Register map (word index = paddr[4:2])
    localparam int unsigned REG_IDX_W = 3;
    localparam int unsigned PADDR_W   = 5;

    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X     = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_X     = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_OFFSET_Y     = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd5;

    // Reset sizes of the glyph
    localparam logic [7:0] GLYPH_WIDTH_RST  = 8'd8;
    localparam logic [7:0] GLYPH_HEIGHT_RST = 8'd8;

    // ARGB8888 layout and alpha codes
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam int unsigned ALPHA_LSB = 24;
    localparam int unsigned RED_LSB   = 16;
    localparam int unsigned GREEN_LSB = 8;
    localparam int unsigned BLUE_LSB  = 0;

    typedef logic [31:0] argb_t;
    typedef logic [7:0]  chan_t;

    // Pixel word held in the input stage register
    typedef struct packed {
        argb_t      src;
        argb_t      bg;
        logic [7:0] column;
        logic [7:0] row;
        logic       last;
    } pix_stage_t;

endpackage

[design/glyph_alpha_blend_blitter.sv]
// ----------------------------------------------------------------------------
// glyph_alpha_blend_blitter
// Places glyph pixels on the surface and blends ARGB8888 source over the
// background (source-over, divide by 255 truncated).
// ----------------------------------------------------------------------------
// The block takes one glyph pixel (with the surface pixel beneath it) per
// clock unless a side stalls, and returns one write word per pixel through
// the input stage register and then the result register. Throughput is one
// word per cycle when not stalled: the column/row counters advance at the
// input edge, and the three channel blends plus the coordinate adds sit in
// one combinational pass between the two registers. Either side may stall;
// the input stage keeps accepting while the result register is being drained.
// Configuration is written over the APB-style port while no glyph is in
// flight; the counters are not touched by register writes.
module glyph_alpha_blend_blitter (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [gaab_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // pixel input
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_source_pixel,
    input  logic [31:0] s_background_pixel,
    // write words out
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_write_enable,
    output logic [15:0] m_write_x,
    output logic [15:0] m_write_y,
    output logic [31:0] m_write_color,
    output logic        m_last_pixel
);

    // Configuration registers
    logic [15:0] origin_x_reg;
    logic [15:0] origin_y_reg;
    logic [7:0]  offset_x_reg;
    logic [7:0]  offset_y_reg;
    logic [7:0]  glyph_width_reg;
    logic [7:0]  glyph_height_reg;

    logic [gaab_pkg::REG_IDX_W-1:0] reg_idx;
    logic                           cfg_wr;

    // Counters and pipeline
    logic [7:0]          column_reg, column_next;
    logic [7:0]          row_reg, row_next;
    logic                row_end, glyph_end;
    gaab_pkg::pix_stage_t stage_reg;
    logic                stage_valid_reg;
    logic                stage_adv;
    logic                s_accept;

    logic        out_valid_reg;
    logic        out_we_reg;
    logic [15:0] out_x_reg;
    logic [15:0] out_y_reg;
    logic [31:0] out_color_reg;
    logic        out_last_reg;

    logic        res_we;
    logic [15:0] res_x;
    logic [15:0] res_y;
    logic [31:0] res_color;
    gaab_pkg::chan_t alpha;
    gaab_pkg::chan_t blend_r, blend_g, blend_b;

    assign pready  = 1'b1;
    assign reg_idx = paddr[gaab_pkg::PADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    // Register writes; unmapped indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
            offset_x_reg     <= '0;
            offset_y_reg     <= '0;
            glyph_width_reg  <= gaab_pkg::GLYPH_WIDTH_RST;
            glyph_height_reg <= gaab_pkg::GLYPH_HEIGHT_RST;
        end else if (cfg_wr) begin
            case (reg_idx)
                gaab_pkg::REG_ORIGIN_X:     origin_x_reg     <= pwdata[15:0];
                gaab_pkg::REG_ORIGIN_Y:     origin_y_reg     <= pwdata[15:0];
                gaab_pkg::REG_OFFSET_X:     offset_x_reg     <= pwdata[7:0];
                gaab_pkg::REG_OFFSET_Y:     offset_y_reg     <= pwdata[7:0];
                gaab_pkg::REG_GLYPH_WIDTH:  glyph_width_reg  <= pwdata[7:0];
                gaab_pkg::REG_GLYPH_HEIGHT: glyph_height_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (reg_idx)
            gaab_pkg::REG_ORIGIN_X:     prdata = {16'd0, origin_x_reg};
            gaab_pkg::REG_ORIGIN_Y:     prdata = {16'd0, origin_y_reg};
            gaab_pkg::REG_OFFSET_X:     prdata = {24'd0, offset_x_reg};
            gaab_pkg::REG_OFFSET_Y:     prdata = {24'd0, offset_y_reg};
            gaab_pkg::REG_GLYPH_WIDTH:  prdata = {24'd0, glyph_width_reg};
            gaab_pkg::REG_GLYPH_HEIGHT: prdata = {24'd0, glyph_height_reg};
            default:                    prdata = '0;
        endcase
    end

    // Handshake: each stage moves when the one after it is free or draining
    assign stage_adv = !out_valid_reg || m_ready;
    assign s_ready   = !stage_valid_reg || stage_adv;
    assign s_accept  = s_valid && s_ready;

    // Row / glyph end; a size of 0 behaves as 1
    assign row_end   = ({1'b0, column_reg} + 9'd1) >= {1'b0, glyph_width_reg};
    assign glyph_end = row_end && (({1'b0, row_reg} + 9'd1) >= {1'b0, glyph_height_reg});

    always_comb begin
        column_next = column_reg;
        row_next    = row_reg;
        if (glyph_end) begin
            column_next = '0;
            row_next    = '0;
        end else if (row_end) begin
            column_next = '0;
            row_next    = row_reg + 8'd1;
        end else begin
            column_next = column_reg + 8'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg <= '0;
            row_reg    <= '0;
        end else if (s_accept) begin
            column_reg <= column_next;
            row_reg    <= row_next;
        end
    end

    // Input stage register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_valid_reg <= 1'b0;
        end else if (s_ready) begin
            stage_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            stage_reg.src    <= s_source_pixel;
            stage_reg.bg     <= s_background_pixel;
            stage_reg.column <= column_reg;
            stage_reg.row    <= row_reg;
            stage_reg.last   <= glyph_end;
        end
    end

    // Target coordinates, modulo 2^16
    assign res_x = origin_x_reg + {8'd0, stage_reg.column}
                 + {{8{offset_x_reg[7]}}, offset_x_reg};
    assign res_y = origin_y_reg + {8'd0, stage_reg.row}
                 + {{8{offset_y_reg[7]}}, offset_y_reg};

    // Channel blend: (s*a + d*(255-a)) / 255, sum fits 16 bits;
    // (x + 1 + (x >> 8)) >> 8 is exact over that range
    function automatic gaab_pkg::chan_t blend_chan(input gaab_pkg::chan_t s,
                                                   input gaab_pkg::chan_t d,
                                                   input gaab_pkg::chan_t a);
        logic [15:0] sum;
        logic [16:0] adj;
        sum = (16'(s) * 16'(a)) + (16'(d) * 16'(gaab_pkg::ALPHA_OPAQUE - a));
        adj = {1'b0, sum} + 17'd1 + {9'd0, sum[15:8]};
        return adj[15:8];
    endfunction

    assign alpha   = stage_reg.src[gaab_pkg::ALPHA_LSB +: 8];
    assign blend_r = blend_chan(stage_reg.src[gaab_pkg::RED_LSB +: 8],
                                stage_reg.bg[gaab_pkg::RED_LSB +: 8], alpha);
    assign blend_g = blend_chan(stage_reg.src[gaab_pkg::GREEN_LSB +: 8],
                                stage_reg.bg[gaab_pkg::GREEN_LSB +: 8], alpha);
    assign blend_b = blend_chan(stage_reg.src[gaab_pkg::BLUE_LSB +: 8],
                                stage_reg.bg[gaab_pkg::BLUE_LSB +: 8], alpha);

    // Color select by alpha
    always_comb begin
        if (alpha == gaab_pkg::ALPHA_CLEAR) begin
            res_we    = 1'b0;
            res_color = '0;
        end else if (alpha == gaab_pkg::ALPHA_OPAQUE) begin
            res_we    = 1'b1;
            res_color = stage_reg.src;
        end else begin
            res_we    = 1'b1;
            res_color = {gaab_pkg::ALPHA_OPAQUE, blend_r, blend_g, blend_b};
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (stage_adv) begin
            out_valid_reg <= stage_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_adv && stage_valid_reg) begin
            out_we_reg    <= res_we;
            out_x_reg     <= res_x;
            out_y_reg     <= res_y;
            out_color_reg <= res_color;
            out_last_reg  <= stage_reg.last;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_write_enable = out_we_reg;
    assign m_write_x      = out_x_reg;
    assign m_write_y      = out_y_reg;
    assign m_write_color  = out_color_reg;
    assign m_last_pixel   = out_last_reg;

endmodule

[design/gaab_checker.sv]
// ----------------------------------------------------------------------------
// gaab_checker
// Port-level checks for the glyph alpha blend blitter, bound to the top.
// ----------------------------------------------------------------------------
module gaab_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_write_enable,
    input logic [15:0] m_write_x,
    input logic [15:0] m_write_y,
    input logic [31:0] m_write_color,
    input logic        m_last_pixel
);

    // Nothing comes out right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result word valid right after reset");

    // Stalled word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_write_enable)
            && $stable(m_write_x) && $stable(m_write_y)
            && $stable(m_write_color) && $stable(m_last_pixel))
        else $error("stalled result word changed");

    // Transparent pixel carries a zero color
    a_clear_color: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_write_enable |-> m_write_color == '0)
        else $error("transparent pixel with nonzero color");

    // A written pixel never has alpha 0
    a_write_alpha: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_write_enable
            |-> m_write_color[gaab_pkg::ALPHA_LSB +: 8] != gaab_pkg::ALPHA_CLEAR)
        else $error("written pixel with alpha 0");

    // Draining the result side always frees the input
    a_drain_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input stalled while result drains");

endmodule

bind glyph_alpha_blend_blitter gaab_checker u_gaab_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_write_enable (m_write_enable),
    .m_write_x      (m_write_x),
    .m_write_y      (m_write_y),
    .m_write_color  (m_write_color),
    .m_last_pixel   (m_last_pixel)
);
